/* sv/sspq_pkg.sv */
// shared types and constants for the stable sorted priority queue
// no dependencies; imported by stable_sorted_priority_queue_core, sspq_checker and tb
package sspq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int PRIO_W    = 16;
  localparam int CODE_W    = 16;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_LIST   = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

endpackage

/* sv/stable_sorted_priority_queue_core.sv */
// an insert reads the tail entry, walks towards the front shifting up each entry that ranks
// behind the key, writes the new entry into the gap and then sends a status beat; remove and
// list read each entry before its beat, and full or empty replies go out as one status beat
// one item in flight at a time; in_tready is high only in the idle state, limited by the
// single read port of the entry store, which the insert walk uses once per cycle
// reset (rst_n low, synchronous) empties the queue and drops any pending output beat;
// the entry store itself is not cleared and needs no clearing pass
module stable_sorted_priority_queue_core
  import sspq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] priority_req (signed), [31:16] code
  input  logic [1:0]  in_tuser,   // [1:0] action
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [15:0] out_priority (signed), [31:16] out_code
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic        out_tlast   // last beat caused by this item
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,   // fetch the tail entry
    S_INS_CMP,  // compare one entry per cycle, shifting it up while it ranks behind the key
    S_INS_PUT,  // drop the new entry into the gap
    S_REM_RD,
    S_REM_OUT,
    S_LST_RD,
    S_LST_OUT,
    S_RES       // single status beat with zero payload
  } state_t;

  // pointer helpers for the circular entry store
  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == LAST_PTR) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    ptr_dec = (p == '0) ? LAST_PTR : p - 1'b1;
  endfunction

  function automatic logic [AW-1:0] ptr_add(input logic [AW-1:0] base,
                                            input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(off);
    if (sum >= (CW+1)'(DEPTH)) begin
      sum = sum - (CW+1)'(DEPTH);
    end
    ptr_add = sum[AW-1:0];
  endfunction

  // entry store, front at head_r, read data registered
  logic signed [PRIO_W-1:0] prio_mem [DEPTH];
  logic        [CODE_W-1:0] code_mem [DEPTH];
  logic signed [PRIO_W-1:0] rd_prio_r;
  logic        [CODE_W-1:0] rd_code_r;
  logic        [AW-1:0]     rd_addr;
  logic                     wr_en;
  logic        [AW-1:0]     wr_addr;
  logic signed [PRIO_W-1:0] wr_prio;
  logic        [CODE_W-1:0] wr_code;

  // control and payload registers
  state_t                   state_r, state_nxt;
  logic        [AW-1:0]     head_r, head_nxt;
  logic        [CW-1:0]     count_r, count_nxt;
  logic        [AW-1:0]     p_r, p_nxt;       // physical address of the entry being walked
  logic        [AW-1:0]     idx_r, idx_nxt;   // its place counted from the front
  logic        [AW-1:0]     pos_r, pos_nxt;   // physical slot for the new entry
  logic signed [PRIO_W-1:0] key_r, key_nxt;
  logic        [CODE_W-1:0] code_r, code_nxt;
  status_t                  res_status_r, res_status_nxt;

  logic                     out_tvalid_r, out_tvalid_nxt;
  status_t                  out_status_r, out_status_nxt;
  logic signed [PRIO_W-1:0] out_prio_r, out_prio_nxt;
  logic        [CODE_W-1:0] out_code_r, out_code_nxt;
  logic                     out_last_r, out_last_nxt;

  logic    in_fire;
  logic    out_free;
  logic    behind;
  action_t in_action;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign in_action  = action_t'(in_tuser);
  // the output register can take a new beat this cycle
  assign out_free   = !out_tvalid_r || out_tready;
  // walked entry ranks strictly behind the new key, so it moves up one slot
  assign behind     = (rd_prio_r > key_r);

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_code_r, out_prio_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    p_nxt          = p_r;
    idx_nxt        = idx_r;
    pos_nxt        = pos_r;
    key_nxt        = key_r;
    code_nxt       = code_r;
    res_status_nxt = res_status_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_prio_nxt   = out_prio_r;
    out_code_nxt   = out_code_r;
    out_last_nxt   = out_last_r;
    rd_addr        = p_r;
    wr_en          = 1'b0;
    wr_addr        = pos_r;
    wr_prio        = key_r;
    wr_code        = code_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          key_nxt  = in_tdata[PRIO_W-1:0];
          code_nxt = in_tdata[PRIO_W+CODE_W-1:PRIO_W];
          case (in_action)
            ACT_INSERT: begin
              if (count_r == FULL_CNT) begin
                res_status_nxt = ST_FULL;
                state_nxt      = S_RES;
              end else if (count_r == '0) begin
                pos_nxt   = head_r;
                state_nxt = S_INS_PUT;
              end else begin
                p_nxt     = ptr_add(head_r, count_r - 1'b1);
                idx_nxt   = AW'(count_r - 1'b1);
                state_nxt = S_INS_RD;
              end
            end
            ACT_REMOVE: begin
              if (count_r == '0) begin
                res_status_nxt = ST_EMPTY;
                state_nxt      = S_RES;
              end else begin
                p_nxt     = head_r;
                state_nxt = S_REM_RD;
              end
            end
            ACT_LIST: begin
              if (count_r == '0) begin
                res_status_nxt = ST_EMPTY;
                state_nxt      = S_RES;
              end else begin
                p_nxt     = head_r;
                idx_nxt   = '0;
                state_nxt = S_LST_RD;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_INS_RD: begin
        state_nxt = S_INS_CMP;
      end

      S_INS_CMP: begin
        // fetch the next entry towards the front while this one is judged
        rd_addr = ptr_dec(p_r);
        if (behind) begin
          wr_en   = 1'b1;
          wr_addr = ptr_inc(p_r);
          wr_prio = rd_prio_r;
          wr_code = rd_code_r;
          if (idx_r == '0) begin
            pos_nxt   = p_r;
            state_nxt = S_INS_PUT;
          end else begin
            p_nxt   = ptr_dec(p_r);
            idx_nxt = idx_r - 1'b1;
          end
        end else begin
          // equal priority stays ahead of the newcomer
          pos_nxt   = ptr_inc(p_r);
          state_nxt = S_INS_PUT;
        end
      end

      S_INS_PUT: begin
        wr_en          = 1'b1;
        count_nxt      = count_r + 1'b1;
        res_status_nxt = ST_OK;
        state_nxt      = S_RES;
      end

      S_REM_RD: begin
        state_nxt = S_REM_OUT;
      end

      S_REM_OUT: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_status_nxt = ST_OK;
          out_prio_nxt   = rd_prio_r;
          out_code_nxt   = rd_code_r;
          out_last_nxt   = 1'b1;
          head_nxt       = ptr_inc(head_r);
          count_nxt      = count_r - 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      S_LST_RD: begin
        state_nxt = S_LST_OUT;
      end

      S_LST_OUT: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_status_nxt = ST_OK;
          out_prio_nxt   = rd_prio_r;
          out_code_nxt   = rd_code_r;
          out_last_nxt   = (idx_r == AW'(count_r - 1'b1));
          if (idx_r == AW'(count_r - 1'b1)) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            p_nxt     = ptr_inc(p_r);
            state_nxt = S_LST_RD;
          end
        end
      end

      S_RES: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_status_nxt = res_status_r;
          out_prio_nxt   = '0;
          out_code_nxt   = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      head_r       <= '0;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      count_r      <= count_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    p_r          <= p_nxt;
    idx_r        <= idx_nxt;
    pos_r        <= pos_nxt;
    key_r        <= key_nxt;
    code_r       <= code_nxt;
    res_status_r <= res_status_nxt;
    out_status_r <= out_status_nxt;
    out_prio_r   <= out_prio_nxt;
    out_code_r   <= out_code_nxt;
    out_last_r   <= out_last_nxt;
  end

  // entry store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      prio_mem[wr_addr] <= wr_prio;
      code_mem[wr_addr] <= wr_code;
    end
    rd_prio_r <= prio_mem[rd_addr];
    rd_code_r <= code_mem[rd_addr];
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("entry count beyond depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INS_PUT) |=> (count_r == $past(count_r) + 1'b1))
    else $error("insert did not add one entry");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REM_OUT && out_free) |=>
      (count_r == $past(count_r) - 1'b1) && out_tvalid_r && out_last_r)
    else $error("remove did not take out one entry");

  a_full_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_action == ACT_INSERT && count_r == FULL_CNT) |=>
      (state_r == S_RES) && (res_status_r == ST_FULL) && $stable(count_r))
    else $error("insert into full queue not dropped");

endmodule

/* verif/sspq_checker.sv */
// result checker for stable_sorted_priority_queue_core: keeps its own sorted copy of the
// queue, works out the beats each accepted item should cause and compares them in order
// depends on sspq_pkg for the action and status codes
`timescale 1ns / 1ps

module sspq_checker
  import sspq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic [1:0]  out_tuser,
  input  logic        out_tlast,
  output int          fail_count,
  output int          beats_waiting,
  output int          beats_checked,
  output int          full_replies,
  output int          empty_replies
);

  typedef struct packed {
    status_t            status;
    logic signed [15:0] prio;
    logic [15:0]        code;
    logic               last;
  } reply_t;

  reply_t             replies_due[$];
  logic signed [15:0] held_prio[DEPTH];
  logic [15:0]        held_code[DEPTH];
  int                 held_count = 0;
  int                 mismatch_count = 0;
  int                 checked_count = 0;
  int                 full_count = 0;
  int                 empty_count = 0;

  assign fail_count    = mismatch_count;
  assign beats_waiting = replies_due.size();
  assign beats_checked = checked_count;
  assign full_replies  = full_count;
  assign empty_replies = empty_count;

  function automatic reply_t make_reply(status_t st, logic signed [15:0] p, logic [15:0] c,
                                        logic lst);
    reply_t r;
    r.status = st;
    r.prio   = p;
    r.code   = c;
    r.last   = lst;
    return r;
  endfunction

  // update the held entries for one item and queue the beats it should produce
  function automatic void apply_queue_action(logic [1:0] act, logic signed [15:0] p,
                                             logic [15:0] c);
    int pos;
    case (act)
      ACT_INSERT: begin
        if (held_count >= DEPTH) begin
          full_count++;
          replies_due.push_back(make_reply(ST_FULL, '0, '0, 1'b1));
        end else begin
          // new entry goes behind every entry of lower or equal priority
          pos = 0;
          while (pos < held_count && held_prio[pos] <= p) pos++;
          for (int i = held_count; i > pos; i--) begin
            held_prio[i] = held_prio[i-1];
            held_code[i] = held_code[i-1];
          end
          held_prio[pos] = p;
          held_code[pos] = c;
          held_count++;
          replies_due.push_back(make_reply(ST_OK, '0, '0, 1'b1));
        end
      end
      ACT_REMOVE: begin
        if (held_count == 0) begin
          empty_count++;
          replies_due.push_back(make_reply(ST_EMPTY, '0, '0, 1'b1));
        end else begin
          replies_due.push_back(make_reply(ST_OK, held_prio[0], held_code[0], 1'b1));
          for (int i = 1; i < held_count; i++) begin
            held_prio[i-1] = held_prio[i];
            held_code[i-1] = held_code[i];
          end
          held_count--;
        end
      end
      ACT_LIST: begin
        if (held_count == 0) begin
          empty_count++;
          replies_due.push_back(make_reply(ST_EMPTY, '0, '0, 1'b1));
        end else begin
          for (int i = 0; i < held_count; i++)
            replies_due.push_back(make_reply(ST_OK, held_prio[i], held_code[i],
                                             i == held_count - 1));
        end
      end
      default: ; // unused code, no beats
    endcase
  endfunction

  function automatic void compare_reply();
    reply_t want;
    if (replies_due.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: unexpected beat status=%0d prio=%0d code=%h last=%b", $time,
                 out_tuser, $signed(out_tdata[15:0]), out_tdata[31:16], out_tlast);
      return;
    end
    want = replies_due.pop_front();
    checked_count++;
    if (out_tuser !== want.status || out_tdata[15:0] !== want.prio ||
        out_tdata[31:16] !== want.code || out_tlast !== want.last) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: beat mismatch, expected status=%0d prio=%0d code=%h last=%b, got %s",
                 $time, want.status, want.prio, want.code, want.last,
                 $sformatf("status=%0d prio=%0d code=%h last=%b", out_tuser,
                           $signed(out_tdata[15:0]), out_tdata[31:16], out_tlast));
    end
  endfunction

  // result beats first, so a stray beat is never masked by the item accepted alongside it
  always @(posedge clk) begin
    if (!rst_n) begin
      held_count = 0;
      replies_due.delete();
    end else begin
      if (out_tvalid && out_tready) compare_reply();
      if (in_tvalid && in_tready) apply_queue_action(in_tuser, in_tdata[15:0], in_tdata[31:16]);
    end
  end

endmodule

/* verif/tb.sv */
// top level testbench for stable_sorted_priority_queue_core: clock, reset, stimulus and verdict
// depends on sspq_pkg, the core and sspq_checker, which does all prediction and comparison
`timescale 1ns / 1ps

module tb;
  import sspq_pkg::*;

  localparam int DEPTH      = DEPTH_DEF;
  localparam int PERIOD     = 12;
  localparam int CYCLE_MAX  = 200000;   // far above the slowest correct run
  localparam int TAIL       = 60;
  localparam int PHASE_LEN  = 26;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;        // [15:0] priority_req (signed), [31:16] code
  logic [1:0]  in_tuser   = '0;        // [1:0] action
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;              // [15:0] out_priority (signed), [31:16] out_code
  logic [1:0]  out_tuser;              // [1:0] status
  logic        out_tlast;

  int fail_count, beats_waiting, beats_checked, full_replies, empty_replies;
  int idle_pct  = 0;                   // chance of a sender gap per cycle
  int stall_pct = 0;                   // chance of a receiver stall per cycle
  int cycle_count = 0;
  int n_insert = 0, n_remove = 0, n_list = 0, n_ignored = 0;

  stable_sorted_priority_queue_core #(.DEPTH(DEPTH)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  sspq_checker #(.DEPTH(DEPTH)) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .out_tlast    (out_tlast),
    .fail_count   (fail_count),
    .beats_waiting(beats_waiting),
    .beats_checked(beats_checked),
    .full_replies (full_replies),
    .empty_replies(empty_replies)
  );

  always #(PERIOD / 2) clk = ~clk;

  // receiver side: random back-pressure, decided fresh each falling edge
  always @(negedge clk) begin
    out_tready <= (stall_pct == 0) ? 1'b1 : ($urandom_range(99) >= stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_MAX) begin
      $display("timeout after %0d cycles, %0d beats still due", cycle_count, beats_waiting);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // one beat on the input channel; entered and left at a falling edge,
  // valid is lowered again only by the next gap or by the caller, never dropped between back-to-back beats
  task automatic send_item(input logic [1:0] act, input logic [15:0] prio,
                           input logic [15:0] code);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= $urandom;           // junk while idle
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {code, prio};
    do @(posedge clk); while (!in_tready);
    case (act)
      ACT_INSERT: n_insert++;
      ACT_REMOVE: n_remove++;
      ACT_LIST:   n_list++;
      default:    n_ignored++;
    endcase
    @(negedge clk);
  endtask

  // priorities lean on a few close values so ties are common, with the extremes mixed in
  function automatic logic [15:0] pick_prio();
    int r;
    r = $urandom_range(9);
    if (r < 4) return 16'($signed($urandom_range(4)) - 2);
    if (r == 4) return $urandom_range(1) ? 16'h7fff : 16'h8000;
    return 16'($urandom);
  endfunction

  // filling phases favour inserts so the queue hits full, draining ones favour removes
  task automatic random_item(input bit draining, output bit counted);
    int         r;
    logic [1:0] act;
    r = $urandom_range(99);
    if (r < 5)                              act = ACT_UNUSED;
    else if (r < 20)                        act = ACT_LIST;
    else if (r < (draining ? 70 : 45))      act = ACT_REMOVE;
    else                                    act = ACT_INSERT;
    send_item(act, pick_prio(), 16'($urandom));
    counted = (act != ACT_UNUSED);
  endtask

  initial begin
    logic [15:0] tie_prio[9];
    bit          counted;
    int          done;

    tie_prio = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff, 16'h0001,
                 16'h0000, 16'h0000, 16'h7fff, 16'h8000};

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty queue replies and an ignored code
    send_item(ACT_LIST,   16'h0000, 16'h0000);
    send_item(ACT_REMOVE, 16'hffff, 16'hffff);
    send_item(ACT_UNUSED, 16'h8000, 16'hffff);

    // fill to capacity with extremes and equal priorities to exercise ordering of ties
    foreach (tie_prio[i])
      send_item(ACT_INSERT, tie_prio[i], (i == 0) ? 16'hffff : 16'(i));
    for (int i = $size(tie_prio); i < DEPTH; i++)
      send_item(ACT_INSERT, pick_prio(), 16'($urandom));

    // dropped insert, full list, then a few removes from the front
    send_item(ACT_INSERT, 16'h0000, 16'hbeef);
    send_item(ACT_LIST,   16'h0000, 16'h0000);
    repeat (3) send_item(ACT_REMOVE, 16'h0000, 16'h0000);

    // random part, one phase per idling pattern
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 74; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 74; end
        default: begin idle_pct = 17; stall_pct = 17; end
      endcase
      done = 0;
      while (done < PHASE_LEN) begin
        random_item(phase[0], counted);
        if (counted) done++;
      end
      // hold the sender off until every due beat has drained
      if (phase == 1) begin
        in_tvalid <= 1'b0;
        while (beats_waiting != 0) @(negedge clk);
      end
    end

    in_tvalid <= 1'b0;
    while (beats_waiting != 0) @(negedge clk);
    repeat (TAIL) @(negedge clk);

    $display("items sent: %0d inserts, %0d removes, %0d lists, %0d ignored codes",
             n_insert, n_remove, n_list, n_ignored);
    $display("%0d result beats checked, %0d full drops and %0d empty replies among them",
             beats_checked, full_replies, empty_replies);
    if (fail_count == 0 && beats_waiting == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* stable_sorted_priority_queue_core.f */
sv/sspq_pkg.sv
sv/stable_sorted_priority_queue_core.sv
verif/sspq_checker.sv
verif/tb.sv
